[hw/rtl/uer_pkg.sv]
`default_nettype none
package uer_pkg;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_TRIG_TICKS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RISE_TIMEOUT = 3'd1;
    localparam logic [IDX_W-1:0] REG_ECHO_TIMEOUT = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCALE_Q16    = 3'd3;
    localparam logic [IDX_W-1:0] REG_BIN_DEPTH    = 3'd4;
    localparam logic [IDX_W-1:0] REG_MIN_DIST     = 3'd5;

    // field widths
    localparam int TRIG_W  = 12;
    localparam int TO_W    = 20;
    localparam int SCALE_W = 16;
    localparam int CM_W    = 10;
    localparam int PCT_W   = 7;
    localparam int NUM_W   = CM_W + PCT_W;   // (dist - min) * 100 fits here

    localparam int DIV_STEPS = 7;
    localparam int DCNT_W    = 3;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // stream words
    localparam int S_TDATA_W = 8;
    localparam int OUT_W     = 20;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic [TRIG_W-1:0]  trig_ticks;
        logic [TO_W-1:0]    rise_timeout;
        logic [TO_W-1:0]    echo_timeout;
        logic [SCALE_W-1:0] scale_q16;
        logic [CM_W-1:0]    depth_cm;
        logic [CM_W-1:0]    min_cm;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        trig_ticks:   12'd192,
        rise_timeout: 20'd65535,
        echo_timeout: 20'd393216,
        scale_q16:    16'd705,
        depth_cm:     10'd50,
        min_cm:       10'd5
    };

    typedef struct packed {
        logic capture;
        logic step;
        logic mul;
        logic clamp;
        logic prep;
        logic div_step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic finish;
        logic need_mul;
        logic need_div;
        logic div_last;
    } t_status;

endpackage
`default_nettype wire

[hw/rtl/uer_regs.sv]
`default_nettype none
module uer_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [uer_pkg::ADDR_W-1:0] i_paddr,
    input  logic [uer_pkg::DATA_W-1:0] i_pwdata,
    output logic [uer_pkg::DATA_W-1:0] o_prdata,
    output logic                       o_pready,
    output uer_pkg::t_cfg              o_cfg
);
    import uer_pkg::*;

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign idx      = i_paddr[ADDR_W-1:2];
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_TRIG_TICKS:   n_cfg.trig_ticks   = i_pwdata[TRIG_W-1:0];
                REG_RISE_TIMEOUT: n_cfg.rise_timeout = i_pwdata[TO_W-1:0];
                REG_ECHO_TIMEOUT: n_cfg.echo_timeout = i_pwdata[TO_W-1:0];
                REG_SCALE_Q16:    n_cfg.scale_q16    = i_pwdata[SCALE_W-1:0];
                REG_BIN_DEPTH:    n_cfg.depth_cm     = i_pwdata[CM_W-1:0];
                REG_MIN_DIST:     n_cfg.min_cm       = i_pwdata[CM_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_TRIG_TICKS:   o_prdata = DATA_W'(r_cfg.trig_ticks);
            REG_RISE_TIMEOUT: o_prdata = DATA_W'(r_cfg.rise_timeout);
            REG_ECHO_TIMEOUT: o_prdata = DATA_W'(r_cfg.echo_timeout);
            REG_SCALE_Q16:    o_prdata = DATA_W'(r_cfg.scale_q16);
            REG_BIN_DEPTH:    o_prdata = DATA_W'(r_cfg.depth_cm);
            REG_MIN_DIST:     o_prdata = DATA_W'(r_cfg.min_cm);
            default:          o_prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/uer_ctrl.sv]
`default_nettype none
module uer_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    input  uer_pkg::t_status i_status,
    output uer_pkg::t_cmd    o_cmd
);
    import uer_pkg::*;

    typedef enum logic [2:0] {
        S_IN,
        S_STEP,
        S_MUL,
        S_CLAMP,
        S_PREP,
        S_DIV,
        S_PUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;
    t_cmd   cmd;

    assign o_s_ready = (r_state == S_IN);
    assign o_m_valid = r_m_valid;
    assign o_cmd     = cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IN: begin
                cmd.capture = i_s_valid;
                if (i_s_valid) n_state = S_STEP;
            end
            S_STEP: begin
                cmd.step = 1'b1;
                if (i_status.finish && i_status.need_mul) n_state = S_MUL;
                else if (i_status.finish)                 n_state = S_PREP;
                else                                      n_state = S_PUT;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.clamp = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = i_status.need_div ? S_DIV : S_PUT;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_PUT;
            end
            S_PUT: begin
                // output register free or emptying this cycle
                cmd.load = !r_m_valid || i_m_ready;
                if (cmd.load) n_state = S_IN;
            end
            default: n_state = S_IN;
        endcase
        n_m_valid = cmd.load ? 1'b1 : (r_m_valid && !i_m_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IN;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/uer_datapath.sv]
`default_nettype none
module uer_datapath #(
    parameter int COUNT_BITS = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  uer_pkg::t_cfg             i_cfg,
    input  uer_pkg::t_cmd             i_cmd,
    input  logic                      i_start,
    input  logic                      i_echo,
    output uer_pkg::t_status          o_status,
    output logic [uer_pkg::OUT_W-1:0] o_word
);
    import uer_pkg::*;

    localparam int CW     = (COUNT_BITS + 1 > TO_W) ? COUNT_BITS + 1 : TO_W;
    localparam int PROD_W = COUNT_BITS + SCALE_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_HIGH
    } t_phase;

    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [COUNT_BITS-1:0]   r_count;
    logic [COUNT_BITS-1:0]   n_count;

    logic                    r_start;
    logic                    r_echo;
    logic                    r_trig;
    logic                    r_done;
    logic                    r_to;
    logic [CM_W-1:0]         r_dist;
    logic [PCT_W-1:0]        r_fill;
    logic [PROD_W-1:0]       r_prod;
    logic [NUM_W-1:0]        r_rem;
    logic [NUM_W-1:0]        r_dsr;
    logic [PCT_W-1:0]        r_quo;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [OUT_W-1:0]        r_word;

    // one tick of the ranging sequence
    logic [COUNT_BITS:0]     inc;
    logic [CW-1:0]           inc_ext;
    logic                    over_rise;
    logic                    over_echo;
    logic                    trig_end;
    logic                    s_trig;
    logic                    s_finish;
    logic                    s_to;
    logic                    s_mul;

    logic [COUNT_BITS-1:0]   prod_cm;
    logic [CM_W-1:0]         clamped;
    logic                    at_empty;
    logic                    at_full;
    logic [CM_W-1:0]         dist_m;
    logic [CM_W-1:0]         den;
    logic                    ge;
    logic [NUM_W-1:0]        rem_n;
    logic [PCT_W-1:0]        quo_n;

    assign inc       = {1'b0, r_count} + 1'b1;
    assign inc_ext   = CW'(inc);
    // carry out of the counter counts as reaching the limit
    assign over_rise = (inc_ext > CW'(i_cfg.rise_timeout)) || inc[COUNT_BITS];
    assign over_echo = (inc_ext > CW'(i_cfg.echo_timeout)) || inc[COUNT_BITS];
    assign trig_end  = r_count >= COUNT_BITS'(i_cfg.trig_ticks);

    always_comb begin
        s_trig   = 1'b0;
        s_finish = 1'b0;
        s_to     = 1'b0;
        s_mul    = 1'b0;
        n_phase  = r_phase;
        n_count  = r_count;
        case (r_phase)
            PH_IDLE: begin
                if (r_start) begin
                    s_trig  = 1'b1;
                    n_phase = PH_TRIG;
                    n_count = COUNT_BITS'(1);
                end
            end
            PH_TRIG: begin
                if (trig_end) begin
                    n_phase = PH_RISE;
                    n_count = '0;
                end else begin
                    s_trig  = 1'b1;
                    n_count = inc[COUNT_BITS-1:0];
                end
            end
            PH_RISE: begin
                if (r_echo) begin
                    n_phase = PH_HIGH;
                    n_count = COUNT_BITS'(1);
                end else if (over_rise) begin
                    s_finish = 1'b1;
                    s_to     = 1'b1;
                    n_phase  = PH_IDLE;
                    n_count  = '0;
                end else begin
                    n_count = inc[COUNT_BITS-1:0];
                end
            end
            PH_HIGH: begin
                if (!r_echo) begin
                    // count kept for the multiply, cleared there
                    s_finish = 1'b1;
                    s_mul    = 1'b1;
                    n_phase  = PH_IDLE;
                end else if (over_echo) begin
                    s_finish = 1'b1;
                    s_to     = 1'b1;
                    n_phase  = PH_IDLE;
                    n_count  = '0;
                end else begin
                    n_count = inc[COUNT_BITS-1:0];
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    assign prod_cm  = r_prod[PROD_W-1:SCALE_W];
    assign clamped  = (prod_cm > COUNT_BITS'(i_cfg.depth_cm)) ? i_cfg.depth_cm
                                                              : prod_cm[CM_W-1:0];
    assign at_empty = r_dist >= i_cfg.depth_cm;
    assign at_full  = r_dist <= i_cfg.min_cm;
    assign dist_m   = r_dist - i_cfg.min_cm;
    assign den      = i_cfg.depth_cm - i_cfg.min_cm;

    // restoring divider, one quotient bit per cycle, MSB first
    assign ge    = r_rem >= r_dsr;
    assign rem_n = ge ? (r_rem - r_dsr) : r_rem;
    assign quo_n = {r_quo[PCT_W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end else if (i_cmd.mul) begin
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_start <= i_start;
            r_echo  <= i_echo;
        end
        if (i_cmd.step) begin
            r_trig <= s_trig;
            r_done <= s_finish;
            r_to   <= s_to;
            r_dist <= s_to ? i_cfg.depth_cm : '0;
            r_fill <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_count) * PROD_W'(i_cfg.scale_q16);
        end
        if (i_cmd.clamp) begin
            r_dist <= clamped;
        end
        if (i_cmd.prep) begin
            if (at_empty) begin
                r_fill <= '0;
            end else if (at_full) begin
                r_fill <= PCT_FULL;
            end
            r_rem  <= NUM_W'(dist_m) * NUM_W'(PCT_FULL);
            r_dsr  <= NUM_W'(den) << (DIV_STEPS - 1);
            r_quo  <= '0;
            r_dcnt <= DCNT_W'(DIV_STEPS - 1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= rem_n;
            r_dsr  <= r_dsr >> 1;
            r_quo  <= quo_n;
            r_dcnt <= r_dcnt - 1'b1;
            if (r_dcnt == '0) r_fill <= PCT_FULL - quo_n;
        end
        if (i_cmd.load) begin
            r_word <= {r_to, r_fill, r_dist, r_done, r_trig};
        end
    end

    assign o_status.finish   = s_finish;
    assign o_status.need_mul = s_mul;
    assign o_status.need_div = !at_empty && !at_full;
    assign o_status.div_last = (r_dcnt == '0);
    assign o_word            = r_word;

endmodule
`default_nettype wire

[hw/rtl/ultrasonic_echo_ranger_core.sv]
// Sequence: each accepted tick word steps the ranger and is loaded into the result register; a tick
//   ending a measurement on echo adds multiply and clamp, and a partial fill the 7-step fill divider.
// Flow: the sequencer handles one word at a time and takes no new tick word until the last one is
//   loaded; the output register frees the input side.
// Reset: synchronous, active low; registers return to defaults, ranger goes idle,
//   no result word pending.
`default_nettype none
module ultrasonic_echo_ranger_core #(
    parameter int COUNT_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uer_pkg::ADDR_W-1:0]    paddr,
    input  logic [uer_pkg::DATA_W-1:0]    pwdata,
    output logic [uer_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // tick words in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [uer_pkg::S_TDATA_W-1:0] s_tdata,   // [0] start_req, [1] echo
    // result words out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] trig, [1] done_res, [11:2] range_cm, [18:12] fill_percent, [19] timed_out
    output logic [uer_pkg::M_TDATA_W-1:0] m_tdata
);
    import uer_pkg::*;

    t_cfg             cfg;
    t_cmd             cmd;
    t_status          status;
    logic [OUT_W-1:0] word;

    uer_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    uer_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    uer_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_cmd    (cmd),
        .i_start  (s_tdata[0]),
        .i_echo   (s_tdata[1]),
        .o_status (status),
        .o_word   (word)
    );

    assign m_tdata = M_TDATA_W'(word);

endmodule
`default_nettype wire

[hw/rtl/uer_checker.sv]
`default_nettype none
module uer_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [uer_pkg::M_TDATA_W-1:0] i_m_tdata
);
    import uer_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result word changed while stalled");

    // distance, fill and timeout flag are zero unless the word reports done
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tdata[1] |-> i_m_tdata[19:2] == '0)
        else $error("result fields set on a word without done");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[18:12] <= PCT_FULL)
        else $error("fill above full scale");

    // trigger phase and measurement end never share a tick
    a_trig_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> !(i_m_tdata[0] && i_m_tdata[1]))
        else $error("trigger high on a finishing tick");

    // timeout reports the bin depth, so the bin reads empty
    a_to_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[19] |-> i_m_tdata[18:12] == '0)
        else $error("timeout with nonzero fill");

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata)
);
`default_nettype wire

[tb/sv/ranger_checker.sv]
module ranger_checker
    import uer_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    input  logic [DATA_W-1:0]    prdata,
    input  logic                 pready,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] start_req, [1] echo
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] trig, [1] done_res, [11:2] range_cm, [18:12] fill_percent, [19] timed_out
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   o_mismatches,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_BITS = 20;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int MAX_PRINTED = 40;

    typedef enum logic [1:0] {
        RNG_IDLE,
        RNG_TRIG,
        RNG_RISE,
        RNG_HIGH
    } t_ranger_phase;

    // last member lands in bit 0, matching the result word layout
    typedef struct packed {
        logic             timed_out;
        logic [PCT_W-1:0] fill_percent;
        logic [CM_W-1:0]  range_cm;
        logic             done_res;
        logic             trig;
    } t_range_word;

    t_cfg                    cfg_shadow = CFG_RESET;
    t_ranger_phase           ranger_phase = RNG_IDLE;
    logic [COUNT_BITS-1:0]   tick_count = '0;
    t_range_word             expected_words[$];
    int                      mismatch_count = 0;
    int                      pending_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ranger_checker: %s mismatch: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
    endtask

    // ends a measurement: clamp to depth, then fill level
    task automatic close_measurement(input logic [COUNT_BITS-1:0] raw_cm, input logic to,
                                     output t_range_word w);
        int depth;
        int floor_cm;
        int clamp_cm;
        depth    = cfg_shadow.depth_cm;
        floor_cm = cfg_shadow.min_cm;
        clamp_cm = (raw_cm > depth) ? depth : int'(raw_cm);
        w = '0;
        w.done_res  = 1'b1;
        w.range_cm  = clamp_cm[CM_W-1:0];
        w.timed_out = to;
        if (clamp_cm >= depth)
            w.fill_percent = '0;
        else if (clamp_cm <= floor_cm)
            w.fill_percent = PCT_FULL;
        else
            w.fill_percent = PCT_W'(100 - ((clamp_cm - floor_cm) * 100) / (depth - floor_cm));
        ranger_phase = RNG_IDLE;
        tick_count   = '0;
    endtask

    task automatic advance_ranger(input logic start_req, input logic echo);
        t_range_word                 w;
        logic [COUNT_BITS:0]         next_count;
        logic [COUNT_BITS+SCALE_W-1:0] product;
        w = '0;
        next_count = {1'b0, tick_count} + 1'b1;
        case (ranger_phase)
            RNG_IDLE: begin
                if (start_req) begin
                    w.trig       = 1'b1;
                    ranger_phase = RNG_TRIG;
                    tick_count   = COUNT_BITS'(1);
                end
            end
            RNG_TRIG: begin
                if (tick_count >= cfg_shadow.trig_ticks) begin
                    ranger_phase = RNG_RISE;
                    tick_count   = '0;
                end else begin
                    w.trig     = 1'b1;
                    tick_count = next_count[COUNT_BITS-1:0];
                end
            end
            RNG_RISE: begin
                if (echo) begin
                    ranger_phase = RNG_HIGH;
                    tick_count   = COUNT_BITS'(1);
                end else if (next_count > cfg_shadow.rise_timeout || next_count > COUNT_MAX) begin
                    close_measurement(COUNT_BITS'(cfg_shadow.depth_cm), 1'b1, w);
                end else begin
                    tick_count = next_count[COUNT_BITS-1:0];
                end
            end
            default: begin
                if (!echo) begin
                    product = tick_count * cfg_shadow.scale_q16;
                    close_measurement(product[COUNT_BITS+SCALE_W-1:SCALE_W], 1'b0, w);
                end else if (next_count > cfg_shadow.echo_timeout || next_count > COUNT_MAX) begin
                    close_measurement(COUNT_BITS'(cfg_shadow.depth_cm), 1'b1, w);
                end else begin
                    tick_count = next_count[COUNT_BITS-1:0];
                end
            end
        endcase
        expected_words.push_back(w);
    endtask

    always @(posedge i_clk) begin
        t_range_word       got;
        t_range_word       want;
        logic [DATA_W-1:0] rd_want;
        if (!i_rst_n) begin
            cfg_shadow   = CFG_RESET;
            ranger_phase = RNG_IDLE;
            tick_count   = '0;
            expected_words.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[ADDR_W-1:2])
                        REG_TRIG_TICKS:   cfg_shadow.trig_ticks   = pwdata[TRIG_W-1:0];
                        REG_RISE_TIMEOUT: cfg_shadow.rise_timeout = pwdata[TO_W-1:0];
                        REG_ECHO_TIMEOUT: cfg_shadow.echo_timeout = pwdata[TO_W-1:0];
                        REG_SCALE_Q16:    cfg_shadow.scale_q16    = pwdata[SCALE_W-1:0];
                        REG_BIN_DEPTH:    cfg_shadow.depth_cm     = pwdata[CM_W-1:0];
                        REG_MIN_DIST:     cfg_shadow.min_cm       = pwdata[CM_W-1:0];
                        default: ;
                    endcase
                end else begin
                    rd_want = '0;
                    case (paddr[ADDR_W-1:2])
                        REG_TRIG_TICKS:   rd_want = DATA_W'(cfg_shadow.trig_ticks);
                        REG_RISE_TIMEOUT: rd_want = DATA_W'(cfg_shadow.rise_timeout);
                        REG_ECHO_TIMEOUT: rd_want = DATA_W'(cfg_shadow.echo_timeout);
                        REG_SCALE_Q16:    rd_want = DATA_W'(cfg_shadow.scale_q16);
                        REG_BIN_DEPTH:    rd_want = DATA_W'(cfg_shadow.depth_cm);
                        REG_MIN_DIST:     rd_want = DATA_W'(cfg_shadow.min_cm);
                        default: ;
                    endcase
                    if (prdata !== rd_want)
                        flag_mismatch("register read", prdata, rd_want);
                end
            end
            if (s_tvalid && s_tready)
                advance_ranger(s_tdata[0], s_tdata[1]);
            if (m_tvalid && m_tready) begin
                got = t_range_word'(m_tdata[OUT_W-1:0]);
                if (expected_words.size() == 0) begin
                    flag_mismatch("unexpected result word", got, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (got.trig !== want.trig)
                        flag_mismatch("trig", got.trig, want.trig);
                    if (got.done_res !== want.done_res)
                        flag_mismatch("done_res", got.done_res, want.done_res);
                    if (got.range_cm !== want.range_cm)
                        flag_mismatch("range_cm", got.range_cm, want.range_cm);
                    if (got.fill_percent !== want.fill_percent)
                        flag_mismatch("fill_percent", got.fill_percent, want.fill_percent);
                    if (got.timed_out !== want.timed_out)
                        flag_mismatch("timed_out", got.timed_out, want.timed_out);
                end
            end
        end
        pending_count <= expected_words.size();
    end

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uer_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_TICKS    = 100;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_W-1:0]    paddr   = '0;
    logic [DATA_W-1:0]    pwdata  = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [0] start_req, [1] echo, upper bits zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] trig, [1] done_res, [11:2] range_cm, [18:12] fill_percent, [19] timed_out
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int plan_trig      = 192;
    int plan_rise      = 65535;
    int plan_echo      = 393216;
    int phase_ticks    = 0;
    int src_pcts[4]    = '{0, 53, 0, 36};
    int sink_pcts[4]   = '{0, 0, 53, 36};

    ultrasonic_echo_ranger_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ranger_checker range_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_tick(input bit start_req, input bit echo);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-2){1'b0}}, echo, start_req};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        phase_ticks++;
    endtask

    // stop offering words and wait for every outstanding result word
    task automatic settle_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic bus_access(input logic wr, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // junk above the register width must be dropped by the block
    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value, input int width);
        logic [DATA_W-1:0] mask;
        mask = DATA_W'((64'd1 << width) - 1);
        bus_access(1'b1, idx, ($urandom & ~mask) | (value & mask));
    endtask

    task automatic read_all_regs();
        bus_access(1'b0, REG_TRIG_TICKS, '0);
        bus_access(1'b0, REG_RISE_TIMEOUT, '0);
        bus_access(1'b0, REG_ECHO_TIMEOUT, '0);
        bus_access(1'b0, REG_SCALE_Q16, '0);
        bus_access(1'b0, REG_BIN_DEPTH, '0);
        bus_access(1'b0, REG_MIN_DIST, '0);
    endtask

    task automatic apply_config(input int trig, rise, echo, scale, depth, floor_cm);
        settle_results();
        write_reg(REG_TRIG_TICKS, trig, TRIG_W);
        write_reg(REG_RISE_TIMEOUT, rise, TO_W);
        write_reg(REG_ECHO_TIMEOUT, echo, TO_W);
        write_reg(REG_SCALE_Q16, scale, SCALE_W);
        write_reg(REG_BIN_DEPTH, depth, CM_W);
        write_reg(REG_MIN_DIST, floor_cm, CM_W);
        read_all_regs();
        plan_trig = trig;
        plan_rise = rise;
        plan_echo = echo;
    endtask

    // one well-formed measurement with random start noise while busy
    task automatic run_measurement(input int high_floor, input int high_cap);
        int  wait_len;
        int  high_len;
        int  allow_high;
        bit  rise_to;
        bit  high_to;
        repeat ($urandom_range(0, 2)) send_tick(1'b0, $urandom_range(0, 1));
        send_tick(1'b1, $urandom_range(0, 1));
        // echo during the trigger is ignored
        repeat ((plan_trig == 0) ? 1 : plan_trig)
            send_tick($urandom_range(0, 1), $urandom_range(0, 1));
        rise_to  = ($urandom_range(99) < 15) && (plan_rise <= 40);
        wait_len = rise_to ? plan_rise + 1 : $urandom_range(0, (plan_rise < 12) ? plan_rise : 12);
        repeat (wait_len) send_tick($urandom_range(0, 1), 1'b0);
        if (rise_to)
            return;
        allow_high = (plan_echo == 0) ? 1 : plan_echo;
        high_to    = ($urandom_range(99) < 15) && (allow_high < high_cap);
        if (high_to)
            high_len = allow_high + 1;
        else
            high_len = $urandom_range((allow_high < high_floor) ? allow_high : high_floor,
                                      (allow_high < high_cap) ? allow_high : high_cap);
        repeat (high_len) send_tick($urandom_range(0, 1), 1'b1);
        if (!high_to)
            send_tick($urandom_range(0, 1), 1'b0);
    endtask

    task automatic run_phase(input int n_ticks, input int src_pct, input int sink_pct,
                             input int high_floor, input int high_cap, input int noise_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        phase_ticks    = 0;
        while (phase_ticks < n_ticks) begin
            if ($urandom_range(99) < noise_pct)
                repeat ($urandom_range(1, 12))
                    send_tick($urandom_range(0, 1), $urandom_range(0, 1));
            else
                run_measurement(high_floor, high_cap);
        end
        settle_results();
    endtask

    task automatic random_config();
        int trig;
        int depth;
        int floor_cm;
        int scale;
        int pick;
        trig  = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 6);
        pick  = $urandom_range(99);
        depth = (pick < 10) ? 1023 : (pick < 20) ? 1 : $urandom_range(2, 60);
        pick  = $urandom_range(99);
        if (pick < 10)
            floor_cm = 0;
        else if (pick < 20)
            floor_cm = 1022;
        else if (pick < 30)
            floor_cm = depth + $urandom_range(0, 3);
        else
            floor_cm = $urandom_range(0, depth);
        pick  = $urandom_range(99);
        scale = (pick < 15) ? 65535 : (pick < 25) ? 0 : $urandom_range(0, 65535);
        apply_config(trig, $urandom_range(0, 12), $urandom_range(0, 20), scale, depth, floor_cm);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_all_regs();
        write_reg(REG_SPARE_LO, $urandom, DATA_W);
        write_reg(REG_SPARE_HI, $urandom, DATA_W);

        // zero trigger length and zero timeouts, full-scale multiply, widest depth
        apply_config(0, 0, 0, 65535, 1023, 0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0); send_tick(1'b1, 1'b1); send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1); send_tick(1'b0, 1'b0); send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b1); send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        // min equal to depth, distance clamps
        apply_config(3, 2, 3, 65535, 1, 1);
        send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b1); send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0); send_tick(1'b0, 1'b0); send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1); send_tick(1'b0, 1'b1); send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        // zero depth, zero scale
        apply_config(1, 5, 5, 0, 0, 0);
        send_tick(1'b1, 1'b1); send_tick(1'b0, 1'b1); send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);

        // long trigger, then longest timeouts with a long echo
        apply_config(200, 4, 6, $urandom_range(0, 65535), 40, 2);
        run_phase(1, 0, 0, 1, 24, 0);
        apply_config(1, 1048575, 1048575, 65535, 1023, $urandom_range(0, 1022));
        run_phase(1, 36, 36, 300, 360, 0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config();
            // result side blocks while words keep coming in, so the input backs up
            if (p == 2)
                hold_requests++;
            run_phase(PHASE_TICKS, src_pcts[p % 4], sink_pcts[p % 4], 1, 24, 12);
        end

        settle_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/uer_pkg.sv
hw/rtl/uer_regs.sv
hw/rtl/uer_ctrl.sv
hw/rtl/uer_datapath.sv
hw/rtl/ultrasonic_echo_ranger_core.sv
hw/rtl/uer_checker.sv
tb/sv/ranger_checker.sv
tb/sv/tb.sv
